// File: sv/swkl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window rank filter package
// Shared types and fixed field widths for the rank filter and its cells.
// ----------------------------------------------------------------------------
package swkl_pkg;

    localparam int WLEN_W = 7;
    localparam int RANK_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic act;
        logic hit;
    } t_wave;

endpackage
`default_nettype wire

// File: sv/swkl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank filter cell
// One entry of the sorted sample chain plus one stage of the rank-count wave.
// ----------------------------------------------------------------------------
module swkl_cell #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 18,
    localparam int AGE_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int CW         = ($clog2(MAX_WINDOW + 1) > swkl_pkg::RANK_W) ?
                                $clog2(MAX_WINDOW + 1) : swkl_pkg::RANK_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_head,
    input  logic                              i_ins,
    input  logic                              i_clear,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_del_shift,
    input  logic                              i_dn_valid,
    input  logic signed [SAMPLE_BITS-1:0]     i_dn_value,
    input  logic [AGE_W-1:0]                  i_dn_age,
    input  logic                              i_up_a_valid,
    input  logic signed [SAMPLE_BITS-1:0]     i_up_a_value,
    input  logic [AGE_W-1:0]                  i_up_a_age,
    input  logic                              i_up_ge,
    output logic                              o_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_value,
    output logic [AGE_W-1:0]                  o_age,
    output logic                              o_del,
    output logic                              o_a_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_a_value,
    output logic [AGE_W-1:0]                  o_a_age,
    output logic                              o_ge,
    input  logic [CW-1:0]                     i_rank,
    input  logic [CW-1:0]                     i_len,
    input  swkl_pkg::t_wave                   i_wave,
    input  logic [CW-1:0]                     i_cnt,
    input  logic signed [SAMPLE_BITS-1:0]     i_val,
    output swkl_pkg::t_wave                   o_wave,
    output logic [CW-1:0]                     o_cnt,
    output logic signed [SAMPLE_BITS-1:0]     o_val
);

    logic                          r_valid, n_valid;
    logic signed [SAMPLE_BITS-1:0] r_value, n_value;
    logic [AGE_W-1:0]              r_age, n_age;
    swkl_pkg::t_wave               r_wave;
    logic [CW-1:0]                 r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_val;
    logic                          in_win;
    logic [CW-1:0]                 cnt_sum;
    logic                          hit_now;

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_del   = r_valid && (r_age == AGE_W'(MAX_WINDOW - 1));

    // The entry seen here after the oldest sample has been taken out of the chain.
    assign o_a_valid = i_del_shift ? i_dn_valid : r_valid;
    assign o_a_value = i_del_shift ? i_dn_value : r_value;
    assign o_a_age   = i_del_shift ? i_dn_age   : r_age;
    assign o_ge      = o_a_valid && (o_a_value >= i_sample);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ins) begin
            priority if (i_clear) begin
                n_valid = i_head;
                n_value = i_sample;
                n_age   = '0;
            end else if (o_ge) begin
                n_valid = 1'b1;
                n_value = o_a_value;
                n_age   = o_a_age + AGE_W'(1);
            end else if (i_up_ge) begin
                n_valid = 1'b1;
                n_value = i_sample;
                n_age   = '0;
            end else begin
                n_valid = i_up_a_valid;
                n_value = i_up_a_value;
                n_age   = i_up_a_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign in_win  = r_valid && (CW'(r_age) < i_len);
    assign cnt_sum = i_cnt + CW'(in_win);
    assign hit_now = in_win && (cnt_sum == i_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave.act <= i_wave.act;
            r_wave.hit <= i_wave.act && (i_wave.hit || hit_now);
        end
        r_cnt <= cnt_sum;
        r_val <= (!i_wave.hit && hit_now) ? r_value : i_val;
    end

    assign o_wave = r_wave;
    assign o_cnt  = r_cnt;
    assign o_val  = r_val;

endmodule
`default_nettype wire

// File: sv/sliding_window_kth_largest.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window k-th largest filter
// Returns the rank-th largest of the most recent window_length samples.
// ----------------------------------------------------------------------------
// Each input word carries a signed sample, the wanted rank and a new-stream
// flag; each output word carries the selected value and a rank error flag.
// Both channels use valid and stall. The window length register is written
// through i_cfg_wr_en and i_cfg_wr_data; the user must write it only while no
// word is in flight, as the block does not enforce this. Samples live in a
// chain of MAX_WINDOW cells kept sorted from largest to smallest, each tagged
// with its age. A word is inserted into the chain at the edge it is accepted;
// a count wave then walks the chain one cell per cycle to find the rank-th
// window member, whose value is registered as the wave leaves the last cell.
// A rank error result skips the wave; a word that yields nothing frees the
// input after the check, others once the result has moved to the output
// register. The output register holds a result while i_stall is high; a
// finished result waits internally until that register is free. Reset empties
// the chain, clears the output and sets the window length to one.
// ----------------------------------------------------------------------------
module sliding_window_kth_largest #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [swkl_pkg::RANK_W-1:0]          i_rank,
    input  logic                                 i_new_stream,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_kth_value,
    output logic                                 o_rank_error,
    input  logic                                 i_cfg_wr_en,
    input  logic [swkl_pkg::WLEN_W-1:0]          i_cfg_wr_data
);

    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = ($clog2(MAX_WINDOW + 1) > swkl_pkg::RANK_W) ?
                           $clog2(MAX_WINDOW + 1) : swkl_pkg::RANK_W;

    swkl_pkg::t_state              r_state, n_state;
    logic [swkl_pkg::WLEN_W-1:0]   r_window_length;
    logic [CW-1:0]                 r_fill;
    logic [CW-1:0]                 r_rank;
    logic signed [SAMPLE_BITS-1:0] r_res_val;
    logic                          r_res_err;
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_kth_value;
    logic                          r_rank_error;

    logic [CW-1:0]                 wl_ext;
    logic [CW-1:0]                 eff_len;
    logic                          accept;
    logic                          full_ok;
    logic                          rank_bad;
    logic                          wave_done;
    logic                          launch;
    logic                          load_err;
    logic                          load_wave;
    logic                          load_out;
    logic                          in_stall;

    logic [MAX_WINDOW-1:0]         del_vec;
    logic [MAX_WINDOW-1:0]         del_shift;

    logic                          c_valid   [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] c_value   [MAX_WINDOW];
    logic [AGE_W-1:0]              c_age     [MAX_WINDOW];
    logic                          c_a_valid [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] c_a_value [MAX_WINDOW];
    logic [AGE_W-1:0]              c_a_age   [MAX_WINDOW];
    logic                          c_ge      [MAX_WINDOW];
    logic                          dn_valid  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] dn_value  [MAX_WINDOW];
    logic [AGE_W-1:0]              dn_age    [MAX_WINDOW];
    logic                          up_valid  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] up_value  [MAX_WINDOW];
    logic [AGE_W-1:0]              up_age    [MAX_WINDOW];
    logic                          up_ge     [MAX_WINDOW];
    swkl_pkg::t_wave               w_wave    [MAX_WINDOW+1];
    logic [CW-1:0]                 w_cnt     [MAX_WINDOW+1];
    logic signed [SAMPLE_BITS-1:0] w_val     [MAX_WINDOW+1];

    assign wl_ext = CW'(r_window_length);

    always_comb begin
        priority if (wl_ext == '0) begin
            eff_len = CW'(1);
        end else if (wl_ext > CW'(MAX_WINDOW)) begin
            eff_len = CW'(MAX_WINDOW);
        end else begin
            eff_len = wl_ext;
        end
    end

    assign accept    = i_valid && !in_stall;
    assign full_ok   = r_fill >= eff_len;
    assign rank_bad  = (r_rank == '0) || (r_rank > eff_len);
    assign wave_done = w_wave[MAX_WINDOW].act;

    // Cells at and below the oldest entry take their lower neighbor's entry.
    assign del_shift = ~(del_vec - MAX_WINDOW'(1));

    assign w_wave[0].act = launch;
    assign w_wave[0].hit = 1'b0;
    assign w_cnt[0]      = '0;
    assign w_val[0]      = '0;

    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        if (gi == MAX_WINDOW - 1) begin : g_tail
            assign dn_valid[gi] = 1'b0;
            assign dn_value[gi] = '0;
            assign dn_age[gi]   = '0;
        end else begin : g_body
            assign dn_valid[gi] = c_valid[gi+1];
            assign dn_value[gi] = c_value[gi+1];
            assign dn_age[gi]   = c_age[gi+1];
        end

        if (gi == 0) begin : g_first
            assign up_valid[gi] = 1'b0;
            assign up_value[gi] = '0;
            assign up_age[gi]   = '0;
            assign up_ge[gi]    = 1'b1;
        end else begin : g_rest
            assign up_valid[gi] = c_a_valid[gi-1];
            assign up_value[gi] = c_a_value[gi-1];
            assign up_age[gi]   = c_a_age[gi-1];
            assign up_ge[gi]    = c_ge[gi-1];
        end

        swkl_cell #(
            .MAX_WINDOW  (MAX_WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_head       (gi == 0),
            .i_ins        (accept),
            .i_clear      (i_new_stream),
            .i_sample     (i_sample),
            .i_del_shift  (del_shift[gi]),
            .i_dn_valid   (dn_valid[gi]),
            .i_dn_value   (dn_value[gi]),
            .i_dn_age     (dn_age[gi]),
            .i_up_a_valid (up_valid[gi]),
            .i_up_a_value (up_value[gi]),
            .i_up_a_age   (up_age[gi]),
            .i_up_ge      (up_ge[gi]),
            .o_valid      (c_valid[gi]),
            .o_value      (c_value[gi]),
            .o_age        (c_age[gi]),
            .o_del        (del_vec[gi]),
            .o_a_valid    (c_a_valid[gi]),
            .o_a_value    (c_a_value[gi]),
            .o_a_age      (c_a_age[gi]),
            .o_ge         (c_ge[gi]),
            .i_rank       (r_rank),
            .i_len        (eff_len),
            .i_wave       (w_wave[gi]),
            .i_cnt        (w_cnt[gi]),
            .i_val        (w_val[gi]),
            .o_wave       (w_wave[gi+1]),
            .o_cnt        (w_cnt[gi+1]),
            .o_val        (w_val[gi+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swkl_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = swkl_pkg::ST_CHECK;
                end
            end
            swkl_pkg::ST_CHECK: begin
                priority if (!full_ok) begin
                    n_state = swkl_pkg::ST_IDLE;
                end else if (rank_bad) begin
                    n_state = swkl_pkg::ST_PUSH;
                end else begin
                    n_state = swkl_pkg::ST_SCAN;
                end
            end
            swkl_pkg::ST_SCAN: begin
                if (wave_done) begin
                    n_state = swkl_pkg::ST_PUSH;
                end
            end
            swkl_pkg::ST_PUSH: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = swkl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swkl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_stall  = 1'b1;
        launch    = 1'b0;
        load_err  = 1'b0;
        load_wave = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            swkl_pkg::ST_IDLE: begin
                in_stall = 1'b0;
            end
            swkl_pkg::ST_CHECK: begin
                launch   = full_ok && !rank_bad;
                load_err = full_ok && rank_bad;
            end
            swkl_pkg::ST_SCAN: begin
                load_wave = wave_done;
            end
            swkl_pkg::ST_PUSH: begin
                load_out = !r_ovalid || !i_stall;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= swkl_pkg::ST_IDLE;
            r_window_length <= swkl_pkg::WLEN_W'(1);
            r_fill          <= '0;
            r_ovalid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window_length <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_new_stream) begin
                    r_fill <= CW'(1);
                end else if (r_fill < CW'(MAX_WINDOW)) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rank <= CW'(i_rank);
        end
        if (load_err) begin
            r_res_val <= '0;
            r_res_err <= 1'b1;
        end else if (load_wave) begin
            r_res_val <= w_val[MAX_WINDOW];
            r_res_err <= 1'b0;
        end
        if (load_out) begin
            r_kth_value  <= r_res_val;
            r_rank_error <= r_res_err;
        end
    end

    assign o_stall      = in_stall;
    assign o_valid      = r_ovalid;
    assign o_kth_value  = r_kth_value;
    assign o_rank_error = r_rank_error;

endmodule
`default_nettype wire

// File: sv/swkl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank filter port checker
// Checks on the filter's ports over time, attached to the top level by bind.
// ----------------------------------------------------------------------------
module swkl_checker #(
    parameter int SAMPLE_BITS = 18
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_kth_value,
    input logic                          o_rank_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kth_value) && $stable(o_rank_error))
        else $error("Stalled output word changed.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rank_error |-> o_kth_value == '0)
        else $error("Rank error word carries a nonzero value.");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Input taken again right after a word was accepted.");

    a_new_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("Output word appeared while the input side was open.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Block not idle after reset.");

endmodule

bind sliding_window_kth_largest swkl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swkl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kth_value  (o_kth_value),
    .o_rank_error (o_rank_error)
);
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding-window k-th largest filter testbench
// Sends sample words through the valid/stall input while random gaps stall
// both sides. Each accepted word goes through an in-bench window model that
// sorts the current window and queues the rank-th largest value, or a rank
// error. Output words are compared against that queue in order. The window
// length is changed between phases, including zero and values above the
// maximum. One phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int SB           = 18;
    localparam int MAXW         = 64;
    localparam int SETTLE       = 80;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_WORDS  = 60;
    localparam int NUM_PHASES   = 14;
    localparam int LENGTHS [NUM_PHASES] = '{127, 3, 64, 1, 16, 65, 2, 0, 33, 100, 7, 5, 64, 12};

    typedef struct packed {
        logic signed [SB-1:0]          sample;
        logic [swkl_pkg::RANK_W-1:0]   rank;
        logic                          fresh;
    } t_word;

    typedef struct packed {
        logic signed [SB-1:0] value;
        logic                 err;
    } t_kth;

    logic                          i_clk;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic signed [SB-1:0]          i_sample      = '0;
    logic [swkl_pkg::RANK_W-1:0]   i_rank        = '0;
    logic                          i_new_stream  = 1'b0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic signed [SB-1:0]          o_kth_value;
    logic                          o_rank_error;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [swkl_pkg::WLEN_W-1:0]   i_cfg_wr_data = '0;

    t_word pending_words [$];
    t_kth  kth_pending [$];

    logic signed [SB-1:0] win_store [MAXW];
    int win_len  = 1;
    int wr_ptr   = 0;
    int fill     = 0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;
    logic rx_hold  = 1'b0;
    int tx_gap     = 0;
    int rx_wait    = 0;
    int quiet_cycles = 0;

    int words_in      = 0;
    int kth_checked   = 0;
    int err_checked   = 0;
    int setting_count = 0;
    int fail_count    = 0;

    sliding_window_kth_largest #(
        .MAX_WINDOW (MAXW),
        .SAMPLE_BITS(SB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_rank       (i_rank),
        .i_new_stream (i_new_stream),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kth_value  (o_kth_value),
        .o_rank_error (o_rank_error),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int effective_len(input int len);
        if (len == 0) return 1;
        if (len > MAXW) return MAXW;
        return len;
    endfunction

    task automatic kth_of_window(input t_word w);
        logic signed [SB-1:0] sorted [MAXW];
        logic signed [SB-1:0] v;
        int eff;
        int n;
        int j;
        t_kth r;
        if (w.fresh) begin
            wr_ptr = 0;
            fill = 0;
        end
        win_store[wr_ptr] = w.sample;
        wr_ptr = (wr_ptr + 1) % MAXW;
        if (fill < MAXW) fill++;
        eff = effective_len(win_len);
        if (fill < eff) return;
        if (w.rank == 0 || int'(w.rank) > eff) begin
            r.value = '0;
            r.err = 1'b1;
        end else begin
            for (n = 0; n < eff; n++) begin
                v = win_store[(wr_ptr + MAXW - 1 - n) % MAXW];
                j = n;
                while (j > 0 && sorted[j-1] < v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            r.value = sorted[int'(w.rank) - 1];
            r.err = 1'b0;
        end
        kth_pending.insert(kth_pending.size(), r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                kth_of_window('{i_sample, i_rank, i_new_stream});
                words_in++;
            end
            if (tx_gap != 0) begin
                i_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (pending_words.size() != 0) begin
                i_valid <= 1'b1;
                i_sample <= pending_words[0].sample;
                i_rank <= pending_words[0].rank;
                i_new_stream <= pending_words[0].fresh;
                void'(pending_words.pop_front());
                tx_gap <= tx_idle_on ? $urandom_range(0, 12) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : kth_monitor
        int rx_left;
        t_kth e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (kth_pending.size() == 0) begin
                    $error("unexpected output word: kth_value %0d rank_error %0b",
                           o_kth_value, o_rank_error);
                    fail_count++;
                end else begin
                    e = kth_pending.pop_front();
                    if (o_kth_value !== e.value) begin
                        $error("kth_value: expected %0d, actual %0d", e.value, o_kth_value);
                        fail_count++;
                    end
                    if (o_rank_error !== e.err) begin
                        $error("rank_error: expected %0b, actual %0b", e.err, o_rank_error);
                        fail_count++;
                    end
                    kth_checked++;
                    if (e.err) err_checked++;
                end
                rx_left = rx_idle_on ? $urandom_range(0, 12) : 0;
            end else begin
                rx_left = (rx_wait != 0) ? rx_wait - 1 : 0;
            end
            rx_wait <= rx_left;
            i_stall <= rx_hold || (rx_left != 0);
        end
    end

    always begin : long_hold
        while (!hold_req) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic queue_word(input int sample, input int rank, input bit fresh);
        t_word w;
        w.sample = sample[SB-1:0];
        w.rank = rank[swkl_pkg::RANK_W-1:0];
        w.fresh = fresh;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_valid || kth_pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_window(input int len);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= len[swkl_pkg::WLEN_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_len = len;
        setting_count++;
    endtask

    function automatic int pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return -(1 << (SB - 1));
        if (sel == 1) return (1 << (SB - 1)) - 1;
        if (sel < 5) return int'($urandom_range(0, 6)) - 3;
        return int'($urandom());
    endfunction

    function automatic int pick_rank(input int eff);
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, eff);
        return $urandom_range(0, (1 << swkl_pkg::RANK_W) - 1);
    endfunction

    initial begin : stimulus
        int p;
        int k;
        int eff;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window length of one.
        queue_word(131071, 1, 1'b1);
        queue_word(-131072, 1, 1'b0);
        queue_word(5, 0, 1'b0);
        queue_word(5, 2, 1'b0);
        queue_word(-1, 127, 1'b0);
        queue_word(0, 1, 1'b1);

        // Filling a window of four, duplicates, bad ranks and a new stream.
        set_window(4);
        queue_word(10, 1, 1'b1);
        queue_word(-20, 4, 1'b0);
        queue_word(10, 2, 1'b0);
        queue_word(7, 3, 1'b0);
        queue_word(10, 1, 1'b0);
        queue_word(-131072, 4, 1'b0);
        queue_word(3, 5, 1'b0);
        queue_word(3, 0, 1'b0);
        queue_word(1, 2, 1'b1);

        // Shorter window over samples already held, then length zero.
        set_window(2);
        queue_word(2, 2, 1'b0);
        set_window(0);
        queue_word(-7, 1, 1'b0);
        queue_word(-7, 2, 1'b0);

        for (p = 0; p < NUM_PHASES; p++) begin
            set_window(LENGTHS[p]);
            tx_idle_on = (p != 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != 1) && ($urandom_range(0, 3) != 0);
            eff = effective_len(LENGTHS[p]);
            for (k = 0; k < PHASE_WORDS; k++) begin
                queue_word(pick_sample(), pick_rank(eff),
                           $urandom_range(0, 4 * eff + 20) == 0);
            end
            if (p == 1) hold_req = 1'b1;
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("Run covered %0d input words over %0d window length settings, %s",
                 words_in, setting_count, "including zero and lengths above the maximum.");
        $display("Checked %0d output words (%0d rank errors) under random and long stalls.",
                 kth_checked, err_checked);
        if (fail_count == 0 && kth_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
sv/swkl_pkg.sv
sv/swkl_cell.sv
sv/sliding_window_kth_largest.sv
sv/swkl_checker.sv
sim/tb.sv
